// File: hdl/mpba_pkg.sv
// Shared types, constants and helpers for the multi-pool bitmap ID allocator.
package mpba_pkg;

   localparam int WORD_W        = 32;
   localparam int WORD_BITS     = 5;
   localparam int ID_W          = 10;
   localparam int OP_W          = 2;
   localparam int POOL_W        = 2;
   localparam int DEF_POOL_SIZE = 1024;
   localparam int DEF_NUM_POOLS = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLAIM = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW
   } state_type;

   typedef struct packed {
      logic write;
      logic success;
      logic full;
   } rmw_res_type;

   function automatic logic [WORD_BITS-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [WORD_BITS-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            idx = WORD_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: hdl/mpba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mpba_ram
   #(
      parameter int WIDTH = 32,
      parameter int DEPTH = 96,
      parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
      input  logic             clock,
      input  logic             we,
      input  logic [AW-1:0]    waddr,
      input  logic [WIDTH-1:0] wdata,
      input  logic             re,
      input  logic [AW-1:0]    raddr,
      output logic [WIDTH-1:0] rdata
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/mpba_summary.sv
// Per-pool word-full flags and lowest non-full word search.
module mpba_summary
   import mpba_pkg::*;
   #(
      parameter int NUM_POOLS = DEF_NUM_POOLS,
      parameter int WPP       = 32,
      parameter int PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
      parameter int WIW       = (WPP > 1) ? $clog2(WPP) : 1
   )
   (
      input  logic           clock,
      input  logic           reset,
      input  logic [PW-1:0]  rd_pool,
      output logic           has_free,
      output logic [WIW-1:0] free_word,
      input  rmw_res_type    upd,
      input  logic [PW-1:0]  upd_pool,
      input  logic [WIW-1:0] upd_word
   );

   logic [WPP-1:0] full_ff [NUM_POOLS];
   logic [WPP-1:0] flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_POOLS; p++) begin
            full_ff[p] <= '0;
         end
      end else if (upd.write) begin
         full_ff[upd_pool][upd_word] <= upd.full;
      end
   end

   always_comb begin
      flags     = full_ff[rd_pool];
      has_free  = ~&flags;
      free_word = '0;
      for (int i = WPP - 1; i >= 0; i--) begin
         if (!flags[i]) begin
            free_word = WIW'(i);
         end
      end
   end

endmodule

// File: hdl/mpba_rmw.sv
// Bitmap word modify: set, clear or pick-and-set one bit and report the outcome.
module mpba_rmw
   import mpba_pkg::*;
   #(
      parameter logic [WORD_W-1:0] PAD_MASK = '0
   )
   (
      input  op_type                op,
      input  logic                  act,
      input  logic                  is_last,
      input  logic [WORD_BITS-1:0]  bit_sel,
      input  logic [WORD_W-1:0]     rdata,
      output logic [WORD_W-1:0]     wdata,
      output logic [WORD_BITS-1:0]  alloc_bit,
      output rmw_res_type           res
   );

   logic [WORD_W-1:0]    pad;
   logic [WORD_BITS-1:0] pos;
   logic [WORD_W-1:0]    onehot;
   logic                 was;

   always_comb begin
      pad       = is_last ? PAD_MASK : '0;
      alloc_bit = first_zero(rdata | pad);
      pos       = (op == OP_ALLOC) ? alloc_bit : bit_sel;
      onehot    = WORD_W'(1) << pos;
      was       = rdata[pos];
      wdata     = rdata;
      res       = '0;
      case (op)
         OP_ALLOC: begin
            wdata       = rdata | onehot;
            res.success = act;
         end
         OP_FREE: begin
            wdata       = rdata & ~onehot;
            res.success = act & was;
         end
         OP_CLAIM: begin
            wdata       = rdata | onehot;
            res.success = act & ~was;
         end
         default: begin
            wdata = rdata;
         end
      endcase
      res.write = act;
      res.full  = &(wdata | pad);
   end

endmodule

// File: hdl/multi_pool_bitmap_id_allocator.sv
// Multi-pool first-fit bitmap ID allocator: control, bitmap memory and result register.
//
// Each request transfer names an operation (allocate, free, claim) and a pool;
// free and claim also carry an ID. Every request gives exactly one response
// transfer with a success flag and an ID.
// The bitmaps sit in one RAM of 32-bit words, ceil(POOL_SIZE/32) words per pool,
// with one full flag per word in registers. The full flags point allocate at
// the lowest word with a free bit; the RAM read of that word is registered,
// and the modified word is written back in ST_RMW.
// rsp_valid is registered and rises after the word update in ST_RMW.
// A new request is taken only in ST_IDLE, once the read-modify-write of the
// last request's bitmap word through the single RAM read/write port pair ends.
// Reset: the full flags clear at once; a clearing pass then writes zeros to
// all NUM_POOLS * ceil(POOL_SIZE/32) RAM words, one per cycle (96 words by
// default), with req_stall high throughout.
// When rsp_stall holds the response, the next request is still taken; its
// write back waits until the response register frees up.
module multi_pool_bitmap_id_allocator
   import mpba_pkg::*;
   #(
      parameter int POOL_SIZE = DEF_POOL_SIZE,
      parameter int NUM_POOLS = DEF_NUM_POOLS
   )
   (
      input  logic              clock,
      input  logic              reset,
      input  logic              req_valid,
      output logic              req_stall,
      input  logic [OP_W-1:0]   req_operation,
      input  logic [POOL_W-1:0] req_pool,
      input  logic [ID_W-1:0]   req_id_in,
      output logic              rsp_valid,
      input  logic              rsp_stall,
      output logic              rsp_success,
      output logic [ID_W-1:0]   rsp_id_out
   );

   localparam int WPP       = (POOL_SIZE + WORD_W - 1) / WORD_W;
   localparam int DEPTH     = NUM_POOLS * WPP;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW        = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int WIW       = (WPP > 1) ? $clog2(WPP) : 1;
   localparam int LAST_BITS = POOL_SIZE - (WPP - 1) * WORD_W;
   localparam logic [WORD_W-1:0] PAD_MASK = (LAST_BITS == WORD_W) ? '0 :
      ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

   state_type state_ff, state_in;

   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   op_type               op_ff, op_in;
   logic                 act_ff, act_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [PW-1:0]        pool_ff, pool_in;
   logic [WIW-1:0]       word_ff, word_in;
   logic [AW-1:0]        addr_ff, addr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_success_ff, rsp_success_in;
   logic [ID_W-1:0]      rsp_id_out_ff, rsp_id_out_in;

   op_type               req_op;
   logic [31:0]          id_wide;
   logic [PW-1:0]        req_pool_idx;
   logic                 pool_ok;
   logic                 id_ok;
   logic                 has_free;
   logic [WIW-1:0]       free_word;
   logic [WIW-1:0]       sel_word;
   logic                 accept;
   logic                 out_free;
   logic                 advance;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_W-1:0]    ram_wdata;
   logic [WORD_W-1:0]    ram_rdata;
   logic [WORD_W-1:0]    new_word;
   logic [WORD_BITS-1:0] alloc_bit;
   rmw_res_type          rmw_res;
   rmw_res_type          sum_upd;
   logic [31:0]          alloc_id_wide;

   assign req_op       = op_type'(req_operation);
   assign id_wide      = 32'(req_id_in);
   assign req_pool_idx = PW'(32'(req_pool));
   assign pool_ok      = 32'(req_pool) < NUM_POOLS;
   assign id_ok        = id_wide < POOL_SIZE;
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = (state_ff == ST_RMW) && out_free;

   mpba_summary #(
      .NUM_POOLS (NUM_POOLS),
      .WPP       (WPP),
      .PW        (PW),
      .WIW       (WIW)
   ) u_summary (
      .clock     (clock),
      .reset     (reset),
      .rd_pool   (req_pool_idx),
      .has_free  (has_free),
      .free_word (free_word),
      .upd       (sum_upd),
      .upd_pool  (pool_ff),
      .upd_word  (word_ff)
   );

   mpba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (addr_in),
      .rdata (ram_rdata)
   );

   mpba_rmw #(
      .PAD_MASK (PAD_MASK)
   ) u_rmw (
      .op        (op_ff),
      .act       (act_ff),
      .is_last   (word_ff == WIW'(WPP - 1)),
      .bit_sel   (id_ff[WORD_BITS-1:0]),
      .rdata     (ram_rdata),
      .wdata     (new_word),
      .alloc_bit (alloc_bit),
      .res       (rmw_res)
   );

   assign alloc_id_wide = (32'(word_ff) << WORD_BITS) | 32'(alloc_bit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      act_ff         <= act_in;
      id_ff          <= id_in;
      pool_ff        <= pool_in;
      word_ff        <= word_in;
      addr_ff        <= addr_in;
      rsp_success_ff <= rsp_success_in;
      rsp_id_out_ff  <= rsp_id_out_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      op_in          = op_ff;
      act_in         = act_ff;
      id_in          = id_ff;
      pool_in        = pool_ff;
      word_in        = word_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_success_in = rsp_success_ff;
      rsp_id_out_in  = rsp_id_out_ff;
      req_stall      = 1'b1;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = new_word;
      sum_upd        = '0;
      sel_word       = (req_op == OP_ALLOC) ? free_word : WIW'(id_wide[WIW+WORD_BITS-1:WORD_BITS]);

      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in   = req_op;
               id_in   = req_id_in;
               pool_in = req_pool_idx;
               word_in = sel_word;
               addr_in = AW'(32'(req_pool_idx) * WPP + 32'(sel_word));
               case (req_op)
                  OP_ALLOC: act_in = pool_ok && has_free;
                  OP_FREE, OP_CLAIM: act_in = pool_ok && id_ok;
                  default: act_in = 1'b0;
               endcase
               state_in = ST_RMW;
            end
         end
         ST_RMW: begin
            if (out_free) begin
               ram_we         = rmw_res.write;
               sum_upd        = rmw_res;
               rsp_valid_in   = 1'b1;
               rsp_success_in = rmw_res.success;
               if (op_ff inside {OP_FREE, OP_CLAIM}) begin
                  rsp_id_out_in = id_ff;
               end else if (op_ff == OP_ALLOC && act_ff) begin
                  rsp_id_out_in = alloc_id_wide[ID_W-1:0];
               end else begin
                  rsp_id_out_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_success = rsp_success_ff;
   assign rsp_id_out  = rsp_id_out_ff;

   a_accept_to_rmw : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RMW)
      else $error("request transfer not followed by word update");

   a_no_write_idle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_we)
      else $error("bitmap write while idle");

   a_rsp_from_rmw : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(state_ff == ST_RMW))
      else $error("response without word update");

   a_write_only_on_advance : assert property (@(posedge clock) disable iff (reset)
      ram_we && state_ff != ST_CLEAR |-> advance && act_ff)
      else $error("bitmap write outside an active update");

endmodule

// File: dv/multi_pool_bitmap_id_allocator_tb.sv
// Self-checking testbench for the multi-pool first-fit bitmap ID allocator.
module multi_pool_bitmap_id_allocator_tb
   import mpba_pkg::*;
   ();

   typedef struct packed {
      op_type            op;
      logic [POOL_W-1:0] pool;
      logic [ID_W-1:0]   id;
   } id_request_type;

   typedef struct packed {
      logic            success;
      logic [ID_W-1:0] id;
   } id_grant_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [OP_W-1:0]   req_operation;
   logic [POOL_W-1:0] req_pool;
   logic [ID_W-1:0]   req_id_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_success;
   logic [ID_W-1:0]   rsp_id_out;

   logic [DEF_POOL_SIZE-1:0] pool_bits [DEF_NUM_POOLS] = '{default: '0};

   id_request_type pending_reqs[$];
   id_grant_type   grants_due[$];
   int             reqs_total;
   int             reqs_sent = 0;
   int             errors = 0;
   int             req_gap;
   int             rsp_hold;
   int             cycle_cnt;
   logic           hold_off;
   logic           no_idle;

   multi_pool_bitmap_id_allocator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_pool      (req_pool),
      .req_id_in     (req_id_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_success   (rsp_success),
      .rsp_id_out    (rsp_id_out)
   );

   always #5 clock = ~clock;

   function automatic id_grant_type apply_request(input id_request_type r);
      id_grant_type g;
      bit           found;
      g.success = 1'b0;
      g.id      = '0;
      found     = 1'b0;
      case (r.op)
         OP_ALLOC: begin
            if (r.pool < DEF_NUM_POOLS) begin
               for (int i = 0; i < DEF_POOL_SIZE; i++) begin
                  if (!found && !pool_bits[r.pool][i]) begin
                     found               = 1'b1;
                     pool_bits[r.pool][i] = 1'b1;
                     g.success           = 1'b1;
                     g.id                = ID_W'(i);
                  end
               end
            end
         end
         OP_FREE, OP_CLAIM: begin
            g.id = r.id;
            if (r.pool < DEF_NUM_POOLS && r.id < DEF_POOL_SIZE) begin
               if (r.op == OP_FREE) begin
                  g.success = pool_bits[r.pool][r.id];
                  pool_bits[r.pool][r.id] = 1'b0;
               end else begin
                  g.success = !pool_bits[r.pool][r.id];
                  pool_bits[r.pool][r.id] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return g;
   endfunction

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void queue_request(input op_type op, input int pool, input int id);
      id_request_type r;
      r.op   = op;
      r.pool = POOL_W'(pool);
      r.id   = ID_W'(id);
      pending_reqs.push_back(r);
   endfunction

   function automatic id_request_type random_request();
      id_request_type r;
      int             roll;
      roll   = $urandom_range(0, 19);
      r.op   = (roll == 0) ? OP_NOP : op_type'(roll % 3);
      r.pool = ($urandom_range(0, 15) == 0) ? POOL_W'(3) : POOL_W'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 7)
         r.id = ID_W'($urandom_range(0, 63));
      else
         r.id = ID_W'($urandom_range(0, 1023));
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cycle_cnt <= 0;
         hold_off  <= 1'b0;
         no_idle   <= 1'b0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         hold_off  <= (cycle_cnt >= 1500 && cycle_cnt < 1800);
         no_idle   <= (cycle_cnt[9:8] == 2'b11);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_operation <= '0;
         req_pool      <= '0;
         req_id_in     <= '0;
         req_gap       <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            grants_due.push_back(apply_request({op_type'(req_operation), req_pool, req_id_in}));
            reqs_sent = reqs_sent + 1;
         end
         if (req_valid && req_stall) begin
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            id_request_type nxt;
            nxt = pending_reqs.pop_front();
            req_operation <= nxt.op;
            req_pool      <= nxt.pool;
            req_id_in     <= nxt.id;
            req_valid     <= 1'b1;
            req_gap       <= idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (grants_due.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual success=%0b id=%0d",
                        $time, rsp_success, rsp_id_out);
               errors = errors + 1;
            end else begin
               id_grant_type want;
               want = grants_due.pop_front();
               if (rsp_success !== want.success) begin
                  $display("%0t: success mismatch, expected %0b actual %0b",
                           $time, want.success, rsp_success);
                  errors = errors + 1;
               end
               if (rsp_id_out !== want.id) begin
                  $display("%0t: id mismatch, expected %0d actual %0d",
                           $time, want.id, rsp_id_out);
                  errors = errors + 1;
               end
            end
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= rsp_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold  <= idle_len();
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL multi_pool_bitmap_id_allocator");
      $finish;
   end

   initial begin
      reset = 1'b1;

      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_ALLOC, 0, 1023);
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_FREE, 0, 1);
      queue_request(OP_FREE, 0, 1);
      queue_request(OP_ALLOC, 0, 0);
      queue_request(OP_CLAIM, 0, 1023);
      queue_request(OP_CLAIM, 0, 1023);
      queue_request(OP_FREE, 0, 1023);
      queue_request(OP_CLAIM, 1, 0);
      queue_request(OP_ALLOC, 1, 0);
      queue_request(OP_ALLOC, 2, 0);
      queue_request(OP_FREE, 2, 'h2AA);
      queue_request(OP_ALLOC, 3, 'h3FF);
      queue_request(OP_FREE, 3, 5);
      queue_request(OP_CLAIM, 3, 'h155);
      queue_request(OP_NOP, 0, 'h3FF);
      queue_request(OP_NOP, 3, 0);
      queue_request(OP_CLAIM, 2, 'h200);
      queue_request(OP_FREE, 2, 'h200);
      queue_request(OP_FREE, 1, 0);
      queue_request(OP_FREE, 1, 0);

      repeat (700) pending_reqs.push_back(random_request());
      for (int n = 0; n < 1060; n++) begin
         if (n % 8 == 7)
            queue_request(op_type'($urandom_range(0, 2)), 2 * $urandom_range(0, 1),
                          $urandom_range(0, 1023));
         else
            queue_request(OP_ALLOC, 1, $urandom_range(0, 1023));
      end
      queue_request(OP_FREE, 1, 'h3FF);
      queue_request(OP_FREE, 1, 'h155);
      queue_request(OP_ALLOC, 1, 0);
      queue_request(OP_ALLOC, 1, 0);
      queue_request(OP_ALLOC, 1, 0);
      queue_request(OP_CLAIM, 1, 'h155);
      repeat (30) pending_reqs.push_back(random_request());
      reqs_total = pending_reqs.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (reqs_sent == reqs_total);
      wait (grants_due.size() == 0);
      repeat (16) @(posedge clock);
      if (errors == 0)
         $display("PASS multi_pool_bitmap_id_allocator");
      else
         $display("FAIL multi_pool_bitmap_id_allocator");
      $finish;
   end

endmodule
